### hw/rtl/mexp_pkg.sv
// mexp_pkg: shared constants and types for the modular exponentiation block.
// Used by the top level, the modular multiplier and the port checker.
// No dependencies.
package mexp_pkg;

    // Default data width of base, modulus, exponent and result
    localparam int DEFAULT_WIDTH = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_MODULUS  = 1'b0;
    localparam cfg_index_t CFG_EXPONENT = 1'b1;

endpackage

### hw/rtl/modular_exponentiation_top.sv
// modular_exponentiation_top: base ^ exponent mod modulus by square-and-multiply.
// Depends on mexp_pkg and mexp_mulmod.
//
//   Configuration: cfg_write with cfg_index selects modulus (index 0) or
//   exponent (index 1); cfg_data is written the same cycle. Write only while
//   the block is idle. Reset values: modulus 2, exponent 1.
//   Input channel: in_valid/in_ready carries base_value. One item is taken
//   at a time; in_ready stays low until its result is posted.
//   Output channel: out_valid/out_ready carries power_result, held in an
//   output register. A stalled receiver holds the result there; the block
//   returns to idle and takes the next item meanwhile, but cannot post a new
//   result until the held one is taken.
//   Sequence: every product runs on the shared shift-add multiplier, with a
//   start and a hand-back. One product reduces the base; then per exponent
//   bit there is a decision state, a multiply where the bit is set and a
//   square (none after the top bit). Modulus zero gives 0 with no product.
//   The next item can be taken in the cycle after a result is posted.
//   Reset: asynchronous, active low; clears control, empties the output.
module modular_exponentiation_top #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  mexp_pkg::cfg_index_t   cfg_index,
    input  logic [WIDTH-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [WIDTH-1:0]       base_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WIDTH-1:0]       power_result
);
    import mexp_pkg::*;

    localparam int IDX_W = $clog2(WIDTH);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_BIT,
        S_MUL,
        S_SQR,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] exponent_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] sq_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             start_reg;
    logic [WIDTH-1:0] op_a_reg;
    logic [WIDTH-1:0] op_b_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] result_reg;

    logic             mul_done;
    logic [WIDTH-1:0] mul_result;
    logic [WIDTH-1:0] one_mod;

    // 1 mod n: zero when the modulus is one
    assign one_mod = (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WIDTH'(2);
            exponent_reg <= WIDTH'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODULUS:  modulus_reg  <= cfg_data;
                CFG_EXPONENT: exponent_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Shared modular multiplier
    mexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .op_a   (op_a_reg),
        .op_b   (op_b_reg),
        .op_n   (modulus_reg),
        .done   (mul_done),
        .result (mul_result)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            sq_reg        <= '0;
            op_a_reg      <= '0;
            op_b_reg      <= '0;
            result_reg    <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            // result taken; in S_FINISH the post below decides
            if (out_valid_reg && out_ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg <= '0;
                        if (modulus_reg == '0)
                        begin
                            acc_reg   <= '0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            // base mod n as base * 1 mod n
                            acc_reg   <= one_mod;
                            op_a_reg  <= base_value;
                            op_b_reg  <= one_mod;
                            start_reg <= 1'b1;
                            state_reg <= S_REDUCE;
                        end
                    end
                end

                S_REDUCE:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= mul_result;
                        state_reg <= S_BIT;
                    end
                end

                S_BIT:
                begin
                    priority if (exponent_reg[idx_reg])
                    begin
                        op_a_reg  <= acc_reg;
                        op_b_reg  <= sq_reg;
                        start_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else if (idx_reg == LAST_BIT)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        op_a_reg  <= sq_reg;
                        op_b_reg  <= sq_reg;
                        start_reg <= 1'b1;
                        state_reg <= S_SQR;
                    end
                end

                S_MUL:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_result;
                        if (idx_reg == LAST_BIT)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            op_a_reg  <= sq_reg;
                            op_b_reg  <= sq_reg;
                            start_reg <= 1'b1;
                            state_reg <= S_SQR;
                        end
                    end
                end

                S_SQR:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= mul_result;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_BIT;
                    end
                end

                S_FINISH:
                begin
                    // post once the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= acc_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;

endmodule

### hw/rtl/mexp_mulmod.sv
// mexp_mulmod: iterative modular multiplier, result = a * b mod n.
// One bit of a per cycle (MSB first): load, WIDTH steps, done after the last.
// Depends on mexp_pkg for the default width. Requires b < n and n >= 1.
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] op_n,
    output logic             done,
    output logic [WIDTH-1:0] result
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] r_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+2:0] diff1;
    logic [WIDTH+2:0] diff2;
    logic [WIDTH-1:0] r_next;

    // One step: r = (2r + bit*b) mod n; 2r + b < 3n, so subtract n or 2n
    always_comb
    begin
        sum   = {1'b0, r_reg, 1'b0} + (a_reg[WIDTH-1] ? {2'b00, b_reg} : '0);
        diff1 = {1'b0, sum} - {3'b000, n_reg};
        diff2 = {1'b0, sum} - {2'b00, n_reg, 1'b0};
        priority if (!diff2[WIDTH+2])
        begin
            r_next = diff2[WIDTH-1:0];
        end
        else if (!diff1[WIDTH+2])
        begin
            r_next = diff1[WIDTH-1:0];
        end
        else
        begin
            r_next = sum[WIDTH-1:0];
        end
    end

    // Control: load on start, count WIDTH steps, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
            n_reg <= op_n;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[WIDTH-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

### hw/rtl/mexp_checker.sv
// mexp_checker: port-level checks on modular_exponentiation_top, bound to it.
// Depends on mexp_pkg; sees only the top level's ports.
module mexp_checker #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_write,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [WIDTH-1:0]     base_value,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [WIDTH-1:0]     power_result
);
    import mexp_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_result))
        else $error("result changed or dropped while stalled");

    // A waiting input item holds its value
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(base_value))
        else $error("input item changed or dropped while waiting");

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item in progress");

    // Posting a result returns the block to idle
    a_idle_on_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("block not idle when result posted");

    // Configuration only while nothing is in flight
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> in_ready && !out_valid)
        else $error("configuration written while an item is in flight");

endmodule

bind modular_exponentiation_top mexp_checker #(
    .WIDTH(WIDTH)
) u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .base_value   (base_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .power_result (power_result)
);
